// ----- hdl/lru_page_replacement_unit_defines.svh -----
// ----------------------------------------------------------------------------
// LRU page replacement unit assertion macros
// Concurrent assertion helpers used by the controller RTL of the unit.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`ifndef SYNTH
`define LRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lru: same-cycle check failed");
`else
`define LRU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

// The consequent must hold in the cycle after the antecedent.
`ifndef SYNTH
`define LRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lru: next-cycle check failed");
`else
`define LRU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hdl/lru_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared types and fixed constants of the controller and datapath.
// ----------------------------------------------------------------------------
package lru_pkg;

	localparam int CfgWidth     = 5;
	localparam int PageInWidth  = 16;
	localparam int SlotOutWidth = 4;
	localparam int CountWidth   = 32;

	localparam logic [CfgWidth-1:0]   FramesInUseReset = 5'd16;
	localparam logic [CountWidth-1:0] CountMax         = 32'hFFFF_FFFF;

	typedef struct packed {
		logic start;
		logic rd_en;
		logic cmp;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
	} ctrl_status_t;

	function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
		sat_inc = (v == CountMax) ? v : v + 32'd1;
	endfunction

endpackage

// ----- hdl/lru_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU controller
// Sequences request intake, the frame table scan, commit and result handoff.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_unit_defines.svh"

module lru_ctrl
	import lru_pkg::*;
#(
	parameter int NUM_FRAMES = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  ctrl_status_t            status,
	output ctrl_cmd_t               cmd,
	output logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)-1:0] rd_idx
);

	localparam int IdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

	state_t          state_q;
	logic [IdxW-1:0] idx_q;
	logic            cmp_q;
	logic            out_valid_q;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign rd_idx     = idx_q;

	always_comb begin
		cmd.start  = in_valid && (state_q == ST_IDLE);
		cmd.rd_en  = (state_q == ST_SCAN);
		cmd.cmp    = cmp_q;
		cmd.commit = (state_q == ST_COMMIT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cmp_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Read data comes back in the cycle after the address is issued.
			cmp_q <= cmd.rd_en;

			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (status.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`LRU_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)
	`LRU_ASSERT_IMP(a_cmp_follows_read, clk, arst_n, cmd.cmp, $past(cmd.rd_en))
	`LRU_ASSERT_IMP(a_drain_has_compare, clk, arst_n, state_q == ST_DRAIN, cmd.cmp)

endmodule

// ----- hdl/lru_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU datapath
// Frame tables, scan compare logic, counters and the result register.
// ----------------------------------------------------------------------------
module lru_dp
	import lru_pkg::*;
#(
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [CfgWidth-1:0]     cfg_write_data,
	input  logic [PageInWidth-1:0]  page_number,
	input  ctrl_cmd_t               cmd,
	input  logic [((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)-1:0] rd_idx,
	output ctrl_status_t            status,
	output logic                    was_hit,
	output logic [SlotOutWidth-1:0] frame_slot,
	output logic                    evicted_valid,
	output logic [PageInWidth-1:0]  evicted_page,
	output logic [CountWidth-1:0]   fault_total,
	output logic [CountWidth-1:0]   hit_total
);

	localparam int IdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam logic [IdxW-1:0] LastFrame = IdxW'(NUM_FRAMES - 1);

	logic [CfgWidth-1:0]   frames_q;
	logic [CfgWidth-1:0]   frames_m1;
	logic [IdxW-1:0]       last_idx;

	logic [PAGE_BITS-1:0]  page_q;
	logic [NUM_FRAMES-1:0] valid_q;
	logic [PAGE_BITS-1:0]  page_mem  [NUM_FRAMES];
	logic [CountWidth-1:0] stamp_mem [NUM_FRAMES];

	logic [PAGE_BITS-1:0]  rd_page_s1;
	logic [CountWidth-1:0] rd_stamp_s1;
	logic [IdxW-1:0]       rd_idx_s1;

	logic                  hit_q;
	logic [IdxW-1:0]       hit_idx_q;
	logic                  empty_q;
	logic [IdxW-1:0]       empty_idx_q;
	logic                  min_seen_q;
	logic [CountWidth-1:0] min_stamp_q;
	logic [IdxW-1:0]       min_idx_q;
	logic [PAGE_BITS-1:0]  min_page_q;

	logic [CountWidth-1:0] use_cnt_q;
	logic [CountWidth-1:0] fault_cnt_q;
	logic [CountWidth-1:0] hit_cnt_q;

	logic                  entry_valid;
	logic                  evict;
	logic [IdxW-1:0]       slot;
	logic [CountWidth-1:0] new_stamp;

	logic                  was_hit_q;
	logic [SlotOutWidth-1:0] frame_slot_q;
	logic                  evicted_valid_q;
	logic [PageInWidth-1:0] evicted_page_q;

	// A zero count acts as one frame; counts above the built size saturate.
	assign frames_m1 = frames_q - 5'd1;
	always_comb begin
		if (frames_q == '0) begin
			last_idx = '0;
		end else if (32'(frames_q) > NUM_FRAMES) begin
			last_idx = LastFrame;
		end else begin
			last_idx = IdxW'(frames_m1);
		end
	end

	assign status.scan_last = (rd_idx == last_idx);

	assign entry_valid = valid_q[rd_idx_s1];
	assign evict       = !hit_q && !empty_q;
	assign new_stamp   = sat_inc(use_cnt_q);

	always_comb begin
		if (hit_q) begin
			slot = hit_idx_q;
		end else if (empty_q) begin
			slot = empty_idx_q;
		end else begin
			slot = min_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FramesInUseReset;
		end else if (cfg_write_en) begin
			frames_q <= cfg_write_data;
		end
	end

	// Frame tables: one registered read and one write per cycle.
	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_q) begin
			page_mem[slot] <= page_q;
		end
		if (cmd.rd_en) begin
			rd_page_s1 <= page_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			stamp_mem[slot] <= new_stamp;
		end
		if (cmd.rd_en) begin
			rd_stamp_s1 <= stamp_mem[rd_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q <= PAGE_BITS'(page_number);
		end
		if (cmd.rd_en) begin
			rd_idx_s1 <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			hit_q       <= 1'b0;
			hit_idx_q   <= '0;
			empty_q     <= 1'b0;
			empty_idx_q <= '0;
			min_seen_q  <= 1'b0;
			min_idx_q   <= '0;
			use_cnt_q   <= '0;
			fault_cnt_q <= '0;
			hit_cnt_q   <= '0;
		end else begin
			if (cmd.start) begin
				hit_q      <= 1'b0;
				empty_q    <= 1'b0;
				min_seen_q <= 1'b0;
			end else if (cmd.cmp) begin
				if (entry_valid && (rd_page_s1 == page_q) && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_s1;
				end
				if (!entry_valid && !empty_q) begin
					empty_q     <= 1'b1;
					empty_idx_q <= rd_idx_s1;
				end
				// Strict compare keeps the lowest index on equal stamps.
				if (entry_valid && (!min_seen_q || (rd_stamp_s1 < min_stamp_q))) begin
					min_seen_q <= 1'b1;
					min_idx_q  <= rd_idx_s1;
				end
			end

			if (cmd.commit) begin
				valid_q[slot] <= 1'b1;
				use_cnt_q     <= new_stamp;
				if (hit_q) begin
					hit_cnt_q <= sat_inc(hit_cnt_q);
				end else begin
					fault_cnt_q <= sat_inc(fault_cnt_q);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp && entry_valid && (!min_seen_q || (rd_stamp_s1 < min_stamp_q))) begin
			min_stamp_q <= rd_stamp_s1;
			min_page_q  <= rd_page_s1;
		end
	end

	// Result register; holds until the next commit.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			was_hit_q       <= hit_q;
			frame_slot_q    <= SlotOutWidth'(slot);
			evicted_valid_q <= evict;
			evicted_page_q  <= evict ? PageInWidth'(min_page_q) : '0;
		end
	end

	assign was_hit       = was_hit_q;
	assign frame_slot    = frame_slot_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_total   = fault_cnt_q;
	assign hit_total     = hit_cnt_q;

endmodule

// ----- hdl/lru_page_replacement_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Least-recently-used frame table that resolves one page request at a time.
// ----------------------------------------------------------------------------
// Each accepted page request scans the active frames one entry per cycle
// through the single read port of the frame table, looking for a match, the
// first empty frame and the oldest stamp together. The scan is followed by a
// drain state for the last read and a commit state that registers the
// result, and only then does the unit return to idle and accept the next
// request. The commit of a request also waits for as long as the previous
// result is held at the output.
// frames_in_use is clamped to the range 1..NUM_FRAMES and should be written
// only while the unit is idle. Counters and the use stamp saturate.
module lru_page_replacement_unit
	import lru_pkg::*;
#(
	parameter int NUM_FRAMES = 16,
	parameter int PAGE_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write_en,
	input  logic [CfgWidth-1:0]     cfg_write_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PageInWidth-1:0]  page_number,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    was_hit,
	output logic [SlotOutWidth-1:0] frame_slot,
	output logic                    evicted_valid,
	output logic [PageInWidth-1:0]  evicted_page,
	output logic [CountWidth-1:0]   fault_total,
	output logic [CountWidth-1:0]   hit_total
);

	localparam int IdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	ctrl_cmd_t       cmd;
	ctrl_status_t    status;
	logic [IdxW-1:0] rd_idx;

	lru_ctrl #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd),
		.rd_idx    (rd_idx)
	);

	lru_dp #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_BITS  (PAGE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.page_number    (page_number),
		.cmd            (cmd),
		.rd_idx         (rd_idx),
		.status         (status),
		.was_hit        (was_hit),
		.frame_slot     (frame_slot),
		.evicted_valid  (evicted_valid),
		.evicted_page   (evicted_page),
		.fault_total    (fault_total),
		.hit_total      (hit_total)
	);

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement unit testbench
// Drives page requests through the valid/ready input and checks each result
// against a behavioral LRU frame table in the bench, or against the typed
// expectation of a directed row. A directed table runs first, then random
// requests under several frame counts with bursty input and output stalls.
// ----------------------------------------------------------------------------
module testbench;
	import lru_pkg::*;

	localparam int NumFrames  = 16;
	localparam int IdleLimit  = 3000;
	localparam int PhaseItems = 65;
	localparam int HoldAfter  = 300;
	localparam int HoldCycles = 400;

	typedef struct packed {
		logic                    was_hit;
		logic [SlotOutWidth-1:0] slot;
		logic                    ev_valid;
		logic [PageInWidth-1:0]  ev_page;
		logic [CountWidth-1:0]   faults;
		logic [CountWidth-1:0]   hits;
	} lru_result_t;

	typedef enum logic {ROW_PAGE, ROW_FRAMES} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [PageInWidth-1:0] value;
		logic                   typed;
		lru_result_t            want;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_write_en = 1'b0;
	logic [CfgWidth-1:0]     cfg_write_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [PageInWidth-1:0]  page_number = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    was_hit;
	logic [SlotOutWidth-1:0] frame_slot;
	logic                    evicted_valid;
	logic [PageInWidth-1:0]  evicted_page;
	logic [CountWidth-1:0]   fault_total;
	logic [CountWidth-1:0]   hit_total;

	// Typed expectation that travels with the request on the bus.
	logic        row_typed = 1'b0;
	lru_result_t row_want = '0;

	// Frame table kept by the bench.
	logic [CfgWidth-1:0]    frames_cfg = FramesInUseReset;
	logic                   res_valid [NumFrames];
	logic [PageInWidth-1:0] res_page [NumFrames];
	logic [CountWidth-1:0]  res_stamp [NumFrames];
	logic [CountWidth-1:0]  use_clock = '0;
	logic [CountWidth-1:0]  fault_cnt = '0;
	logic [CountWidth-1:0]  hit_cnt = '0;

	lru_result_t            pending_results [$];
	logic [PageInWidth-1:0] recent_pages [$];
	logic [PageInWidth-1:0] pool_base = '0;
	int                     errors = 0;
	int                     results_seen = 0;
	int                     quiet_cycles = 0;
	int                     burst_left = 1;

	logic [CfgWidth-1:0] phase_frames [10] = '{5'd16, 5'd4, 5'd0, 5'd1, 5'd31,
		5'd7, 5'd17, 5'd2, 5'd16, 5'd12};

	stim_row_t dir_table [19] = '{
		'{ROW_PAGE,   16'h0000, 1'b1, '{1'b0, 4'd0, 1'b0, 16'h0, 32'd1, 32'd0}},
		'{ROW_PAGE,   16'hFFFF, 1'b1, '{1'b0, 4'd1, 1'b0, 16'h0, 32'd2, 32'd0}},
		'{ROW_PAGE,   16'h0000, 1'b1, '{1'b1, 4'd0, 1'b0, 16'h0, 32'd2, 32'd1}},
		'{ROW_PAGE,   16'hFFFF, 1'b1, '{1'b1, 4'd1, 1'b0, 16'h0, 32'd2, 32'd2}},
		'{ROW_PAGE,   16'h5555, 1'b0, '0},
		'{ROW_PAGE,   16'hAAAA, 1'b0, '0},
		'{ROW_FRAMES, 16'd0,    1'b0, '0},
		'{ROW_PAGE,   16'hFFFF, 1'b0, '0},
		'{ROW_PAGE,   16'hFFFF, 1'b0, '0},
		'{ROW_FRAMES, 16'd31,   1'b0, '0},
		'{ROW_PAGE,   16'hFFFF, 1'b0, '0},
		'{ROW_FRAMES, 16'd2,    1'b0, '0},
		'{ROW_PAGE,   16'h5555, 1'b0, '0},
		'{ROW_PAGE,   16'h0001, 1'b0, '0},
		'{ROW_PAGE,   16'h5555, 1'b0, '0},
		'{ROW_FRAMES, 16'd16,   1'b0, '0},
		'{ROW_PAGE,   16'h8000, 1'b0, '0},
		'{ROW_PAGE,   16'h7FFF, 1'b0, '0},
		'{ROW_PAGE,   16'hAAAA, 1'b0, '0}
	};

	lru_page_replacement_unit #(
		.NUM_FRAMES(NumFrames),
		.PAGE_BITS (PageInWidth)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.page_number   (page_number),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.was_hit       (was_hit),
		.frame_slot    (frame_slot),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total),
		.hit_total     (hit_total)
	);

	always #10 clk = ~clk;

	function automatic logic [CountWidth-1:0] bump_count(input logic [CountWidth-1:0] v);
		return (v == CountMax) ? v : v + 32'd1;
	endfunction

	function automatic int unsigned frames_managed();
		if (frames_cfg == 0)
			return 1;
		return (frames_cfg > NumFrames) ? NumFrames : frames_cfg;
	endfunction

	// Looks the page up in the bench's frame table and applies the LRU update.
	function automatic lru_result_t resolve_page(input logic [PageInWidth-1:0] pg);
		int unsigned active;
		int unsigned slot;
		bit          found;
		bit          placed;
		lru_result_t r;
		r = '0;
		found = 1'b0;
		placed = 1'b0;
		slot = 0;
		active = frames_managed();
		for (int i = 0; i < active; i++)
			if (!found && res_valid[i] && res_page[i] == pg) begin
				found = 1'b1;
				slot = i;
			end
		if (!found) begin
			for (int i = 0; i < active; i++)
				if (!placed && !res_valid[i]) begin
					placed = 1'b1;
					slot = i;
				end
			if (!placed) begin
				slot = 0;
				for (int i = 1; i < active; i++)
					if (res_stamp[i] < res_stamp[slot])
						slot = i;
				r.ev_valid = 1'b1;
				r.ev_page = res_page[slot];
			end
			res_valid[slot] = 1'b1;
			res_page[slot] = pg;
			fault_cnt = bump_count(fault_cnt);
		end else begin
			hit_cnt = bump_count(hit_cnt);
		end
		use_clock = bump_count(use_clock);
		res_stamp[slot] = use_clock;
		r.was_hit = found;
		r.slot = slot[SlotOutWidth-1:0];
		r.faults = fault_cnt;
		r.hits = hit_cnt;
		return r;
	endfunction

	// Mostly a working set a little larger than the managed frames, so that
	// hits and evictions both happen; the rest is recent reuse and noise.
	function automatic logic [PageInWidth-1:0] pick_page();
		int unsigned roll;
		logic [PageInWidth-1:0] pg;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			pg = pool_base + PageInWidth'($urandom_range(0, frames_managed() + 2));
		else if (roll < 85 && recent_pages.size() != 0)
			pg = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
		else
			pg = PageInWidth'($urandom());
		recent_pages.push_back(pg);
		if (recent_pages.size() > 8)
			void'(recent_pages.pop_front());
		return pg;
	endfunction

	task automatic report_mismatch(input string what, input logic [CountWidth-1:0] got,
		input logic [CountWidth-1:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	task automatic idle_cycles(input int n);
		in_valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Called at a falling edge; returns at a falling edge after acceptance and any burst gap.
	task automatic send_page(input logic [PageInWidth-1:0] pg, input logic typed,
		input lru_result_t want);
		int gap;
		in_valid <= 1'b1;
		page_number <= pg;
		row_typed <= typed;
		row_want <= want;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0)
				idle_cycles(gap);
		end
	endtask

	// Waits until the unit has returned every request, then writes the register.
	task automatic set_frames(input logic [CfgWidth-1:0] value);
		idle_cycles(1);
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= value;
		frames_cfg = value;
		@(negedge clk);
		cfg_write_en <= 1'b0;
	endtask

	always @(posedge clk) begin : monitor
		lru_result_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				want = resolve_page(page_number);
				pending_results.push_back(row_typed ? row_want : want);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, hit_total", hit_total, '0);
				end else begin
					want = pending_results.pop_front();
					if (was_hit !== want.was_hit)
						report_mismatch("was_hit", was_hit, want.was_hit);
					if (frame_slot !== want.slot)
						report_mismatch("frame_slot", frame_slot, want.slot);
					if (evicted_valid !== want.ev_valid)
						report_mismatch("evicted_valid", evicted_valid, want.ev_valid);
					if (evicted_page !== want.ev_page)
						report_mismatch("evicted_page", evicted_page, want.ev_page);
					if (fault_total !== want.faults)
						report_mismatch("fault_total", fault_total, want.faults);
					if (hit_total !== want.hits)
						report_mismatch("hit_total", hit_total, want.hits);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= IdleLimit) begin
					$display("FAIL");
					$finish;
				end
			end
		end
	end

	// Result side: always ready, random stalls, or a fixed rotating pattern,
	// taken in turn, plus one long hold-off that lets the unit back up and
	// stall its request input.
	initial begin : receiver
		int         rx_cycle;
		bit         held;
		logic [7:0] pattern;
		rx_cycle = 0;
		held = 1'b0;
		pattern = 8'b1011_0010;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (!held && results_seen >= HoldAfter) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
			end else begin
				case ((rx_cycle / 700) % 3)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 2) != 0);
					default: begin
						pattern = {pattern[6:0], pattern[7]};
						out_ready <= pattern[0];
					end
				endcase
			end
		end
	end

	initial begin
		for (int i = 0; i < NumFrames; i++) begin
			res_valid[i] = 1'b0;
			res_page[i] = '0;
			res_stamp[i] = '0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_FRAMES)
				set_frames(dir_table[i].value[CfgWidth-1:0]);
			else
				send_page(dir_table[i].value, dir_table[i].typed, dir_table[i].want);
		end

		foreach (phase_frames[p]) begin
			set_frames(phase_frames[p]);
			pool_base = PageInWidth'($urandom());
			for (int k = 0; k < PhaseItems; k++)
				send_page(pick_page(), 1'b0, '0);
		end

		idle_cycles(1);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
